// ----- rtl/core/rftbb_pkg.sv -----
`default_nettype none

package rftbb_pkg;

  localparam int unsigned FRAC_BITS = 30;

  typedef enum logic [2:0] {
    OP_PT_LOCAL   = 3'd0,
    OP_VEC_LOCAL  = 3'd1,
    OP_PT_GLOBAL  = 3'd2,
    OP_VEC_GLOBAL = 3'd3,
    OP_BOX        = 3'd4
  } op_t;

  localparam logic [1:0] CFG_COS      = 2'd0;
  localparam logic [1:0] CFG_SIN      = 2'd1;
  localparam logic [1:0] CFG_ORIGIN_X = 2'd2;
  localparam logic [1:0] CFG_ORIGIN_Y = 2'd3;

  localparam logic signed [31:0] COS_RESET = 32'sh4000_0000;

  typedef struct packed {
    logic signed [31:0] cos_term;
    logic signed [31:0] sin_term;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
  } cfg_t;

  typedef struct packed {
    op_t                op;
    logic               last;
    logic signed [31:0] rx;
    logic signed [31:0] ry;
    logic signed [31:0] z;
  } rot_item_t;

  // v = exact sum scaled by 2^30 plus rounding term; floor shift and clamp
  function automatic logic signed [31:0] round_sat(input logic signed [67:0] v);
    logic signed [37:0] q;
    q = v[67:FRAC_BITS];
    if (q[37:31] != {7{q[37]}}) begin
      round_sat = q[37] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      round_sat = q[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rotated_frame_transform_bbox_unit.sv -----
`default_nettype none
// An accepted input transaction reaches out_tvalid through registered stages (origin subtract,
// 33x32 products, round/saturate, box fold and output register).
// Throughput: one transaction per cycle; a stalled sink (out_tready low) holds the flow.
// Box points without tlast and unused opcodes produce no output transaction.
// Reset (rst_n low, synchronous): pipeline empty, box closed and zeroed,
// cos_term = 1.0, sin_term = 0, origin = 0.

module rotated_frame_transform_bbox_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [95:0]  in_tdata,   // in_x, in_y, in_z
  input  wire logic [2:0]   in_tuser,   // opcode
  input  wire logic         in_tlast,   // last_point
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [191:0]      out_tdata,  // res_x, res_y, res_z, hi_x, hi_y, hi_z
  output logic              out_tuser   // is_box
);
  import rftbb_pkg::*;

  cfg_t      cfg_r;
  logic      rot_valid, rot_ready;
  rot_item_t rot_item;

  logic               box_open_r, box_open_nxt;
  logic signed [31:0] lo_x_r, lo_y_r, lo_z_r, hi_x_r, hi_y_r, hi_z_r;
  logic signed [31:0] lo_x_nxt, lo_y_nxt, lo_z_nxt, hi_x_nxt, hi_y_nxt, hi_z_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic signed [31:0] res_x_r, res_y_r, res_z_r, res_hx_r, res_hy_r, res_hz_r;
  logic               is_box_r;
  logic               fire, emit;

  rftbb_rotate u_rotate (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_x     ($signed(in_tdata[31:0])),
    .in_y     ($signed(in_tdata[63:32])),
    .in_z     ($signed(in_tdata[95:64])),
    .in_last  (in_tlast),
    .dn_valid (rot_valid),
    .dn_ready (rot_ready),
    .dn_item  (rot_item)
  );

  assign rot_ready = !out_valid_r || out_tready;
  assign fire      = rot_valid && rot_ready;
  assign emit      = fire && ((rot_item.op != OP_BOX) || rot_item.last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cos_term <= COS_RESET;
      cfg_r.sin_term <= '0;
      cfg_r.origin_x <= '0;
      cfg_r.origin_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_COS:      cfg_r.cos_term <= $signed(cfg_wdata);
        CFG_SIN:      cfg_r.sin_term <= $signed(cfg_wdata);
        CFG_ORIGIN_X: cfg_r.origin_x <= $signed(cfg_wdata);
        CFG_ORIGIN_Y: cfg_r.origin_y <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  // running box with this point folded in
  always_comb begin
    if (!box_open_r) begin
      lo_x_nxt = rot_item.rx;
      lo_y_nxt = rot_item.ry;
      lo_z_nxt = rot_item.z;
      hi_x_nxt = rot_item.rx;
      hi_y_nxt = rot_item.ry;
      hi_z_nxt = rot_item.z;
    end else begin
      lo_x_nxt = (rot_item.rx < lo_x_r) ? rot_item.rx : lo_x_r;
      lo_y_nxt = (rot_item.ry < lo_y_r) ? rot_item.ry : lo_y_r;
      lo_z_nxt = (rot_item.z  < lo_z_r) ? rot_item.z  : lo_z_r;
      hi_x_nxt = (rot_item.rx > hi_x_r) ? rot_item.rx : hi_x_r;
      hi_y_nxt = (rot_item.ry > hi_y_r) ? rot_item.ry : hi_y_r;
      hi_z_nxt = (rot_item.z  > hi_z_r) ? rot_item.z  : hi_z_r;
    end
    box_open_nxt  = !rot_item.last;
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_open_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lo_x_r      <= '0;
      lo_y_r      <= '0;
      lo_z_r      <= '0;
      hi_x_r      <= '0;
      hi_y_r      <= '0;
      hi_z_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (fire && (rot_item.op == OP_BOX)) begin
        box_open_r <= box_open_nxt;
        if (rot_item.last) begin
          lo_x_r <= '0;
          lo_y_r <= '0;
          lo_z_r <= '0;
          hi_x_r <= '0;
          hi_y_r <= '0;
          hi_z_r <= '0;
        end else begin
          lo_x_r <= lo_x_nxt;
          lo_y_r <= lo_y_nxt;
          lo_z_r <= lo_z_nxt;
          hi_x_r <= hi_x_nxt;
          hi_y_r <= hi_y_nxt;
          hi_z_r <= hi_z_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (rot_item.op == OP_BOX) begin
        res_x_r  <= lo_x_nxt;
        res_y_r  <= lo_y_nxt;
        res_z_r  <= lo_z_nxt;
        res_hx_r <= hi_x_nxt;
        res_hy_r <= hi_y_nxt;
        res_hz_r <= hi_z_nxt;
        is_box_r <= 1'b1;
      end else begin
        res_x_r  <= rot_item.rx;
        res_y_r  <= rot_item.ry;
        res_z_r  <= rot_item.z;
        res_hx_r <= '0;
        res_hy_r <= '0;
        res_hz_r <= '0;
        is_box_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_hz_r, res_hy_r, res_hx_r, res_z_r, res_y_r, res_x_r};
  assign out_tuser  = is_box_r;

  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && is_box_r |-> res_x_r <= res_hx_r && res_y_r <= res_hy_r
      && res_z_r <= res_hz_r)
    else $error("box minimum above maximum");

  a_xform_hi_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !is_box_r |-> res_hx_r == 0 && res_hy_r == 0 && res_hz_r == 0)
    else $error("transform result carries box maximum");

  a_box_closed_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit && rot_item.op == OP_BOX |=> !box_open_r && lo_x_r == 0 && hi_x_r == 0)
    else $error("box not cleared after emit");

  a_closed_box_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !box_open_r |-> lo_y_r == 0 && lo_z_r == 0 && hi_y_r == 0 && hi_z_r == 0)
    else $error("closed box holds stale bounds");

endmodule

`default_nettype wire

// ----- rtl/core/rftbb_rotate.sv -----
`default_nettype none

module rftbb_rotate (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire rftbb_pkg::cfg_t           cfg,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [2:0]                in_op,
  input  wire logic signed [31:0]        in_x,
  input  wire logic signed [31:0]        in_y,
  input  wire logic signed [31:0]        in_z,
  input  wire logic                      in_last,
  output logic                           dn_valid,
  input  wire logic                      dn_ready,
  output rftbb_pkg::rot_item_t           dn_item
);
  import rftbb_pkg::*;

  localparam logic signed [67:0] RND = 68'sh2000_0000;

  // stage 1: origin removed for local points and box points
  logic               s1_v_r, s1_v_nxt;
  op_t                s1_op_r;
  logic               s1_last_r;
  logic signed [32:0] s1_a_r, s1_b_r, s1_a_nxt, s1_b_nxt;
  logic signed [31:0] s1_z_r;

  // stage 2: products
  logic               s2_v_r, s2_v_nxt;
  op_t                s2_op_r;
  logic               s2_last_r;
  logic signed [31:0] s2_z_r;
  logic signed [64:0] s2_ac_r, s2_bs_r, s2_as_r, s2_bc_r;

  // stage 3: rounded result
  logic               s3_v_r, s3_v_nxt;
  rot_item_t          s3_item_r, s3_item_nxt;

  logic s1_rdy, s2_rdy, s3_rdy, op_ok;

  assign s3_rdy   = !s3_v_r || dn_ready;
  assign s2_rdy   = !s2_v_r || s3_rdy;
  assign s1_rdy   = !s1_v_r || s2_rdy;
  assign in_ready = s1_rdy;
  assign op_ok    = in_op <= 3'(OP_BOX);

  assign dn_valid = s3_v_r;
  assign dn_item  = s3_item_r;

  always_comb begin
    logic sub_origin;
    sub_origin = (in_op == 3'(OP_PT_LOCAL)) || (in_op == 3'(OP_BOX));
    s1_a_nxt   = sub_origin ? 33'(in_x) - 33'(cfg.origin_x) : 33'(in_x);
    s1_b_nxt   = sub_origin ? 33'(in_y) - 33'(cfg.origin_y) : 33'(in_y);
    s1_v_nxt   = s1_rdy ? (in_valid && op_ok) : s1_v_r;
    s2_v_nxt   = s2_rdy ? s1_v_r : s2_v_r;
    s3_v_nxt   = s3_rdy ? s2_v_r : s3_v_r;
  end

  always_comb begin
    logic signed [67:0] sx, sy, offx, offy;
    logic               to_local;
    case (s2_op_r)
      OP_PT_LOCAL, OP_VEC_LOCAL, OP_BOX: to_local = 1'b1;
      OP_PT_GLOBAL, OP_VEC_GLOBAL:       to_local = 1'b0;
      default:                           to_local = 1'b1;
    endcase
    offx = (s2_op_r == OP_PT_GLOBAL) ? (68'(cfg.origin_x) <<< FRAC_BITS) : '0;
    offy = (s2_op_r == OP_PT_GLOBAL) ? (68'(cfg.origin_y) <<< FRAC_BITS) : '0;
    if (to_local) begin
      sx = 68'(s2_ac_r) + 68'(s2_bs_r);
      sy = 68'(s2_bc_r) - 68'(s2_as_r);
    end else begin
      sx = 68'(s2_ac_r) - 68'(s2_bs_r);
      sy = 68'(s2_as_r) + 68'(s2_bc_r);
    end
    s3_item_nxt.op   = s2_op_r;
    s3_item_nxt.last = s2_last_r;
    s3_item_nxt.rx   = round_sat(sx + offx + RND);
    s3_item_nxt.ry   = round_sat(sy + offy + RND);
    s3_item_nxt.z    = s2_z_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
      s3_v_r <= s3_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_rdy) begin
      s1_op_r   <= op_t'(in_op);
      s1_last_r <= in_last;
      s1_a_r    <= s1_a_nxt;
      s1_b_r    <= s1_b_nxt;
      s1_z_r    <= in_z;
    end
    if (s1_v_r && s2_rdy) begin
      s2_op_r   <= s1_op_r;
      s2_last_r <= s1_last_r;
      s2_z_r    <= s1_z_r;
      s2_ac_r   <= s1_a_r * cfg.cos_term;
      s2_bs_r   <= s1_b_r * cfg.sin_term;
      s2_as_r   <= s1_a_r * cfg.sin_term;
      s2_bc_r   <= s1_b_r * cfg.cos_term;
    end
    if (s2_v_r && s3_rdy) begin
      s3_item_r <= s3_item_nxt;
    end
  end

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r && !dn_ready |=> s3_v_r && $stable(s3_item_r))
    else $error("stage 3 item changed while stalled");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && !s3_rdy |=> s2_v_r && $stable(s2_ac_r) && $stable(s2_bc_r))
    else $error("stage 2 products changed while stalled");

  a_bad_op_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !op_ok && !s2_rdy |=> !s1_v_r || $stable(s1_op_r))
    else $error("unused opcode entered the pipeline");

endmodule

`default_nettype wire
